[rtl/plu_pkg.sv]
`timescale 1ns / 1ps
package plu_pkg;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    // micro-ops of the shared multiplier, issued in this order
    typedef enum logic [3:0] {
        OP_DISP_X,
        OP_DISP_Y,
        OP_DISP_Z,
        OP_GRAV_X,
        OP_GRAV_Y,
        OP_GRAV_Z,
        OP_POS_X,
        OP_POS_Y,
        OP_POS_Z,
        OP_SIZE,
        OP_SPIN,
        OP_COL0,
        OP_COL1,
        OP_COL2,
        OP_COL3
    } t_op;

    typedef enum logic [1:0] {
        SH_8,
        SH_12,
        SH_16
    } t_shift;

    typedef struct packed {
        logic   vld;
        t_op    tag;
        t_shift sh;
    } t_mul_req;

    typedef struct packed {
        logic vld;
        t_op  tag;
    } t_mul_rsp;

    localparam logic [2:0] REG_SIZE_RANGE     = 3'd0;
    localparam logic [2:0] REG_SPIN_RANGE     = 3'd1;
    localparam logic [2:0] REG_COLOR_RANGE    = 3'd2;
    localparam logic [2:0] REG_SPEED          = 3'd3;
    localparam logic [2:0] REG_LIFETIME       = 3'd4;
    localparam logic [2:0] REG_START_POSITION = 3'd5;
    localparam logic [2:0] REG_DIRECTION      = 3'd6;
    localparam logic [2:0] REG_START_GRAVITY  = 3'd7;

    localparam logic [23:0] LIFE_MIN  = 24'h800000;
    localparam logic [16:0] RATIO_ONE = 17'h10000;

endpackage

[rtl/plu_div.sv]
`timescale 1ns / 1ps
module plu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [7:0]  i_den,
    output logic        o_done,
    output logic [16:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [15:0] r_q;
    logic [7:0]  r_den;
    logic [8:0]  w_trial;
    logic        w_bit;
    logic [8:0]  w_rem_next;

    assign w_trial    = {r_rem, r_q[15]};
    assign w_bit      = (w_trial >= {1'b0, r_den});
    assign w_rem_next = w_bit ? (w_trial - {1'b0, r_den}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_start) begin
            r_cnt <= 4'd0;
            // quotient of 65536 or more clamps without iterating
            priority if (i_den == 8'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_ovf  <= 1'b0;
            end else if (i_num[23:16] >= i_den) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_ovf  <= 1'b1;
            end else begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_ovf  <= 1'b0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[23:16];
            r_q   <= (i_den == 8'd0) ? 16'd0 : i_num[15:0];
        end else if (r_busy) begin
            r_rem <= w_rem_next[7:0];
            r_q   <= {r_q[14:0], w_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_ovf ? plu_pkg::RATIO_ONE : {1'b0, r_q};

endmodule

[rtl/plu_mrs.sv]
`timescale 1ns / 1ps
module plu_mrs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plu_pkg::t_mul_req   i_req,
    input  logic signed [31:0]  i_a,
    input  logic signed [17:0]  i_b,
    output plu_pkg::t_mul_rsp   o_rsp,
    output logic signed [31:0]  o_res,
    output logic                o_busy
);

    plu_pkg::t_mul_req  r_s1;
    plu_pkg::t_mul_req  r_s2;
    logic signed [31:0] r_a;
    logic signed [17:0] r_b;
    logic signed [49:0] r_prod;
    logic signed [50:0] w_ext;
    logic signed [50:0] w_rnd;
    logic signed [50:0] w_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_req;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_b    <= i_b;
        r_prod <= r_a * r_b;
    end

    assign w_ext = {r_prod[49], r_prod};

    // round half up, then arithmetic shift (floor)
    always_comb begin
        w_rnd = w_ext;
        w_shr = w_ext;
        unique case (r_s2.sh)
            plu_pkg::SH_8: begin
                w_rnd = w_ext + 51'sd128;
                w_shr = w_rnd >>> 8;
            end
            plu_pkg::SH_12: begin
                w_rnd = w_ext + 51'sd2048;
                w_shr = w_rnd >>> 12;
            end
            plu_pkg::SH_16: begin
                w_rnd = w_ext + 51'sd32768;
                w_shr = w_rnd >>> 16;
            end
            default: begin
                w_rnd = w_ext;
                w_shr = w_ext;
            end
        endcase
    end

    always_comb begin
        priority if (w_shr > 51'sd2147483647) begin
            o_res = 32'sh7FFFFFFF;
        end else if (w_shr < -51'sd2147483648) begin
            o_res = 32'sh80000000;
        end else begin
            o_res = w_shr[31:0];
        end
    end

    assign o_rsp.vld = r_s2.vld;
    assign o_rsp.tag = r_s2.tag;
    assign o_busy    = r_s1.vld | r_s2.vld;

endmodule

[rtl/particle_lifetime_update.sv]
`timescale 1ns / 1ps
// channel  dir  payload                                   handshake
// -------  ---  ----------------------------------------  ------------------
// in       in   i_op, i_time_step                         i_valid / o_ready
// out      out  o_pos_x/y/z, o_cur_size/spin/color,       o_valid / i_ready
//               o_life_ratio, o_expired
// cfg      in   i_cfg_idx, i_cfg_data                     i_cfg_we, no wait
//
// per item, from accept to result, the 16-step divider for
// the life ratio runs beside the nine motion multiplies, then six interpolation
// multiplies follow on the one shared multiplier; a zero lifetime or a full ratio
// ends the divide without iterating; a restart skips the motion multiplies.
// reset is synchronous and restarts the particle from the reset configuration.
// a new item is taken while a result waits and then holds until the output is free.
module particle_lifetime_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [15:0]        i_time_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [15:0]        o_cur_size,
    output logic signed [15:0] o_cur_spin,
    output logic [31:0]        o_cur_color,
    output logic [16:0]        o_life_ratio,
    output logic               o_expired,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] == v[31]) begin
            r = v[31:0];
        end else begin
            r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return r;
    endfunction

    function automatic logic [15:0] f_clamp_u16(input logic signed [32:0] v);
        logic [15:0] r;
        priority if (v[32]) begin
            r = 16'h0000;
        end else if (|v[31:16]) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] f_clamp_s16(input logic signed [32:0] v);
        logic [15:0] r;
        if ((&v[32:15]) || !(|v[32:15])) begin
            r = v[15:0];
        end else begin
            r = v[32] ? 16'h8000 : 16'h7FFF;
        end
        return r;
    endfunction

    function automatic logic [7:0] f_clamp_u8(input logic signed [32:0] v);
        logic [7:0] r;
        priority if (v[32]) begin
            r = 8'h00;
        end else if (|v[31:8]) begin
            r = 8'hFF;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    // configuration
    logic [31:0] r_size_range;
    logic [31:0] r_spin_range;
    logic [63:0] r_color_range;
    logic [15:0] r_speed;
    logic [7:0]  r_lifetime;
    logic [47:0] r_start_pos;
    logic [47:0] r_dir;
    logic [47:0] r_start_grav;

    // particle state
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [31:0] r_grav_x, r_grav_y, r_grav_z;
    logic signed [31:0] r_disp_x, r_disp_y, r_disp_z;
    logic [23:0]        r_life;
    logic [7:0]         r_total;
    logic               r_expired;
    logic [15:0]        r_dt;
    logic [15:0]        r_size;
    logic [15:0]        r_spin;
    logic [31:0]        r_color;

    // sequencer
    plu_pkg::t_state r_state, n_state;
    plu_pkg::t_op    r_step;
    logic            r_step_on;
    logic            w_in_ready;
    logic            w_accept;
    logic            w_issue;
    logic            w_finish;
    logic            w_is_lerp;

    // output register
    logic               r_out_vld;
    logic signed [31:0] r_out_pos_x, r_out_pos_y, r_out_pos_z;
    logic [15:0]        r_out_size;
    logic [15:0]        r_out_spin;
    logic [31:0]        r_out_color;
    logic [16:0]        r_out_ratio;
    logic               r_out_expired;

    // life and ratio
    logic [24:0]  w_ldiff;
    logic [23:0]  n_life;
    logic [7:0]   n_total;
    logic [23:0]  w_div_num;
    logic         w_div_done;
    logic [16:0]  w_ratio;
    logic [16:0]  w_inv;

    // shared multiplier
    plu_pkg::t_mul_req  w_req;
    plu_pkg::t_mul_rsp  w_rsp;
    logic signed [31:0] w_a;
    logic signed [17:0] w_b;
    logic signed [31:0] w_res;
    logic               w_mul_busy;

    logic [15:0]        w_dsel;
    logic signed [31:0] w_gsel;
    logic [32:0]        w_dir33;
    logic signed [32:0] w_sum33;
    logic signed [31:0] w_sum;
    logic [7:0]         w_cs, w_ce;
    logic signed [31:0] w_size_diff;
    logic signed [31:0] w_spin_diff;
    logic signed [31:0] w_col_diff;
    logic signed [31:0] w_lstart;
    logic signed [32:0] w_lsum;

    assign w_accept = i_valid & w_in_ready;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plu_pkg::S_IDLE: if (w_accept) n_state = plu_pkg::S_RUN;
            plu_pkg::S_RUN:  if (w_finish) n_state = plu_pkg::S_IDLE;
            default:         n_state = plu_pkg::S_IDLE;
        endcase
    end

    assign w_is_lerp = (r_step >= plu_pkg::OP_SIZE);

    always_comb begin
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            plu_pkg::S_IDLE: w_in_ready = 1'b1;
            plu_pkg::S_RUN: begin
                // interpolation waits for the ratio
                w_issue  = r_step_on && (!w_is_lerp || w_div_done);
                w_finish = !r_step_on && !w_mul_busy && w_div_done
                           && (!r_out_vld || i_ready);
            end
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= plu_pkg::OP_DISP_X;
            r_step_on <= 1'b0;
        end else if (w_accept) begin
            r_step    <= i_op ? plu_pkg::OP_SIZE : plu_pkg::OP_DISP_X;
            r_step_on <= 1'b1;
        end else if (w_issue) begin
            if (r_step == plu_pkg::OP_COL3) begin
                r_step_on <= 1'b0;
            end else begin
                r_step <= plu_pkg::t_op'(r_step + 4'd1);
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_range  <= 32'd0;
            r_spin_range  <= 32'd0;
            r_color_range <= 64'd0;
            r_speed       <= 16'd256;
            r_lifetime    <= 8'd1;
            r_start_pos   <= 48'd0;
            r_dir         <= 48'd0;
            r_start_grav  <= 48'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plu_pkg::REG_SIZE_RANGE:     r_size_range  <= i_cfg_data[31:0];
                plu_pkg::REG_SPIN_RANGE:     r_spin_range  <= i_cfg_data[31:0];
                plu_pkg::REG_COLOR_RANGE:    r_color_range <= i_cfg_data;
                plu_pkg::REG_SPEED:          r_speed       <= i_cfg_data[15:0];
                plu_pkg::REG_LIFETIME:       r_lifetime    <= i_cfg_data[7:0];
                plu_pkg::REG_START_POSITION: r_start_pos   <= i_cfg_data[47:0];
                plu_pkg::REG_DIRECTION:      r_dir         <= i_cfg_data[47:0];
                plu_pkg::REG_START_GRAVITY:  r_start_grav  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // life update on accept
    assign w_ldiff = {r_life[23], r_life} - {9'd0, i_time_step};

    always_comb begin
        if (i_op) begin
            n_life  = {4'd0, r_lifetime, 12'd0};
            n_total = r_lifetime;
        end else begin
            n_life  = (w_ldiff[24] != w_ldiff[23]) ? plu_pkg::LIFE_MIN : w_ldiff[23:0];
            n_total = r_total;
        end
    end

    assign w_div_num = (!n_life[23] && (n_life != 24'd0)) ? {n_life[19:0], 4'd0} : 24'd0;

    plu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (w_div_num),
        .i_den   (n_total),
        .o_done  (w_div_done),
        .o_quo   (w_ratio)
    );

    assign w_inv = plu_pkg::RATIO_ONE - w_ratio;

    // operand selection for the issued op
    always_comb begin
        w_dsel = r_dir[15:0];
        w_gsel = r_grav_x;
        w_cs   = r_color_range[7:0];
        w_ce   = r_color_range[39:32];
        unique case (r_step)
            plu_pkg::OP_DISP_Y: begin
                w_dsel = r_dir[31:16];
                w_gsel = r_grav_y;
            end
            plu_pkg::OP_DISP_Z: begin
                w_dsel = r_dir[47:32];
                w_gsel = r_grav_z;
            end
            plu_pkg::OP_COL1: begin
                w_cs = r_color_range[15:8];
                w_ce = r_color_range[47:40];
            end
            plu_pkg::OP_COL2: begin
                w_cs = r_color_range[23:16];
                w_ce = r_color_range[55:48];
            end
            plu_pkg::OP_COL3: begin
                w_cs = r_color_range[31:24];
                w_ce = r_color_range[63:56];
            end
            default: ;
        endcase
    end

    assign w_dir33     = {{9{w_dsel[15]}}, w_dsel, 8'd0};
    assign w_sum33     = w_dir33 + {w_gsel[31], w_gsel};
    assign w_sum       = f_sat32(w_sum33);
    assign w_size_diff = {16'd0, r_size_range[31:16]} - {16'd0, r_size_range[15:0]};
    assign w_spin_diff = {{16{r_spin_range[31]}}, r_spin_range[31:16]}
                         - {{16{r_spin_range[15]}}, r_spin_range[15:0]};
    assign w_col_diff  = {24'd0, w_ce} - {24'd0, w_cs};

    always_comb begin
        w_req     = '0;
        w_req.vld = w_issue;
        w_req.tag = r_step;
        w_req.sh  = plu_pkg::SH_12;
        w_a       = r_grav_x;
        w_b       = {2'd0, r_dt};
        unique case (r_step)
            plu_pkg::OP_DISP_X, plu_pkg::OP_DISP_Y, plu_pkg::OP_DISP_Z: begin
                w_a      = w_sum;
                w_b      = {2'd0, r_speed};
                w_req.sh = plu_pkg::SH_8;
            end
            plu_pkg::OP_GRAV_X: w_a = r_grav_x;
            plu_pkg::OP_GRAV_Y: w_a = r_grav_y;
            plu_pkg::OP_GRAV_Z: w_a = r_grav_z;
            plu_pkg::OP_POS_X:  w_a = r_disp_x;
            plu_pkg::OP_POS_Y:  w_a = r_disp_y;
            plu_pkg::OP_POS_Z:  w_a = r_disp_z;
            plu_pkg::OP_SIZE: begin
                w_a      = w_size_diff;
                w_b      = {1'b0, w_inv};
                w_req.sh = plu_pkg::SH_16;
            end
            plu_pkg::OP_SPIN: begin
                w_a      = w_spin_diff;
                w_b      = {1'b0, w_inv};
                w_req.sh = plu_pkg::SH_16;
            end
            plu_pkg::OP_COL0, plu_pkg::OP_COL1, plu_pkg::OP_COL2, plu_pkg::OP_COL3: begin
                w_a      = w_col_diff;
                w_b      = {1'b0, w_inv};
                w_req.sh = plu_pkg::SH_16;
            end
            default: ;
        endcase
    end

    plu_mrs u_mrs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_res   (w_res),
        .o_busy  (w_mul_busy)
    );

    // start value of the interpolation that is written back
    always_comb begin
        w_lstart = {16'd0, r_size_range[15:0]};
        unique case (w_rsp.tag)
            plu_pkg::OP_SPIN: w_lstart = {{16{r_spin_range[15]}}, r_spin_range[15:0]};
            plu_pkg::OP_COL0: w_lstart = {24'd0, r_color_range[7:0]};
            plu_pkg::OP_COL1: w_lstart = {24'd0, r_color_range[15:8]};
            plu_pkg::OP_COL2: w_lstart = {24'd0, r_color_range[23:16]};
            plu_pkg::OP_COL3: w_lstart = {24'd0, r_color_range[31:24]};
            default: ;
        endcase
    end

    assign w_lsum = {w_lstart[31], w_lstart} + {w_res[31], w_res};

    // particle state: restart or life step on accept, results on write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 32'sd0;
            r_pos_y   <= 32'sd0;
            r_pos_z   <= 32'sd0;
            r_grav_x  <= 32'sd0;
            r_grav_y  <= 32'sd0;
            r_grav_z  <= 32'sd0;
            r_life    <= 24'd4096;
            r_total   <= 8'd1;
            r_expired <= 1'b0;
        end else if (w_accept) begin
            r_life  <= n_life;
            r_total <= n_total;
            if (i_op) begin
                r_pos_x  <= {{8{r_start_pos[15]}}, r_start_pos[15:0], 8'd0};
                r_pos_y  <= {{8{r_start_pos[31]}}, r_start_pos[31:16], 8'd0};
                r_pos_z  <= {{8{r_start_pos[47]}}, r_start_pos[47:32], 8'd0};
                r_grav_x <= {{8{r_start_grav[15]}}, r_start_grav[15:0], 8'd0};
                r_grav_y <= {{8{r_start_grav[31]}}, r_start_grav[31:16], 8'd0};
                r_grav_z <= {{8{r_start_grav[47]}}, r_start_grav[47:32], 8'd0};
            end else if (n_life[23] || (n_life == 24'd0)) begin
                r_expired <= 1'b1;
            end
        end else if (w_rsp.vld) begin
            unique case (w_rsp.tag)
                plu_pkg::OP_GRAV_X: r_grav_x <= f_sat32({r_grav_x[31], r_grav_x} + {w_res[31], w_res});
                plu_pkg::OP_GRAV_Y: r_grav_y <= f_sat32({r_grav_y[31], r_grav_y} + {w_res[31], w_res});
                plu_pkg::OP_GRAV_Z: r_grav_z <= f_sat32({r_grav_z[31], r_grav_z} + {w_res[31], w_res});
                plu_pkg::OP_POS_X:  r_pos_x  <= f_sat32({r_pos_x[31], r_pos_x} + {w_res[31], w_res});
                plu_pkg::OP_POS_Y:  r_pos_y  <= f_sat32({r_pos_y[31], r_pos_y} + {w_res[31], w_res});
                plu_pkg::OP_POS_Z:  r_pos_z  <= f_sat32({r_pos_z[31], r_pos_z} + {w_res[31], w_res});
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt <= i_time_step;
        end
        if (w_rsp.vld) begin
            unique case (w_rsp.tag)
                plu_pkg::OP_DISP_X: r_disp_x <= w_res;
                plu_pkg::OP_DISP_Y: r_disp_y <= w_res;
                plu_pkg::OP_DISP_Z: r_disp_z <= w_res;
                plu_pkg::OP_SIZE:   r_size   <= f_clamp_u16(w_lsum);
                plu_pkg::OP_SPIN:   r_spin   <= f_clamp_s16(w_lsum);
                plu_pkg::OP_COL0:   r_color[7:0]   <= f_clamp_u8(w_lsum);
                plu_pkg::OP_COL1:   r_color[15:8]  <= f_clamp_u8(w_lsum);
                plu_pkg::OP_COL2:   r_color[23:16] <= f_clamp_u8(w_lsum);
                plu_pkg::OP_COL3:   r_color[31:24] <= f_clamp_u8(w_lsum);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_finish) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_pos_x   <= r_pos_x;
            r_out_pos_y   <= r_pos_y;
            r_out_pos_z   <= r_pos_z;
            r_out_size    <= r_size;
            r_out_spin    <= r_spin;
            r_out_color   <= r_color;
            r_out_ratio   <= w_ratio;
            r_out_expired <= r_expired;
        end
    end

    assign o_ready      = w_in_ready;
    assign o_valid      = r_out_vld;
    assign o_pos_x      = r_out_pos_x;
    assign o_pos_y      = r_out_pos_y;
    assign o_pos_z      = r_out_pos_z;
    assign o_cur_size   = r_out_size;
    assign o_cur_spin   = r_out_spin;
    assign o_cur_color  = r_out_color;
    assign o_life_ratio = r_out_ratio;
    assign o_expired    = r_out_expired;

    a_lerp_after_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.vld && (w_req.tag >= plu_pkg::OP_SIZE)) |-> w_div_done)
        else $error("interpolation issued before the ratio was ready");

    a_expired_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expired |=> r_expired)
        else $error("expired flag cleared without reset");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_life_ratio <= plu_pkg::RATIO_ONE))
        else $error("life ratio above one");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plu_pkg::S_IDLE) |-> !w_mul_busy)
        else $error("multiplier busy while idle");

endmodule
